@@ hw/rtl/mcld_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor command line decoder package
// Character codes, keyword tables, result codes and the result struct.
// ----------------------------------------------------------------------------
package mcld_pkg;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int unsigned NUM_TOKENS = 3;   // index, third and fourth token
  localparam int unsigned KW_CNT     = 4;
  localparam int unsigned TXT_DEPTH  = 16;

  localparam logic [3:0] FWD_LEN = 4'd7;

  // magnitude is clamped here once it runs past any valid 32-bit value
  localparam logic [31:0] MAG_CAP     = 32'h8000_0001;
  localparam logic [31:0] MAG_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] MAG_NEG_MAX = 32'h8000_0000;

  localparam logic [2:0] TOK_MAX = 3'd7;
  localparam logic [3:0] LEN_MAX = 4'd15;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    KIND_DC      = 2'd0,
    KIND_DC_ENC  = 2'd1,
    KIND_STEPPER = 2'd2,
    KIND_SERVO   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOKEN_COUNT = 2'd1,
    ST_BAD_NUMBER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [31:0] device_index;
    logic        reverse;
    logic [31:0] amount;
  } result_t;

  localparam logic [7:0] KW_TXT [KW_CNT][TXT_DEPTH] = '{
    '{0: "D", 1: "C", default: 8'h00},
    '{0: "D", 1: "C", 2: "_", 3: "e", 4: "n", 5: "c", 6: "o", 7: "d", 8: "e", 9: "r",
      default: 8'h00},
    '{0: "S", 1: "t", 2: "e", 3: "p", 4: "p", 5: "e", 6: "r", default: 8'h00},
    '{0: "S", 1: "e", 2: "r", 3: "v", 4: "o", default: 8'h00}
  };

  localparam logic [7:0] FWD_TXT [8] = '{
    0: "F", 1: "o", 2: "r", 3: "w", 4: "a", 5: "r", 6: "d", default: 8'h00
  };

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] len;
    case (k)
      2'd0:    len = 4'd2;
      2'd1:    len = 4'd10;
      2'd2:    len = 4'd7;
      default: len = 4'd5;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/mcld_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one received character until the parser takes it.
// ----------------------------------------------------------------------------
module mcld_in_stage import mcld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] ch
  input  logic                  take,
  output logic                  ch_vld,
  output logic [7:0]            ch
);

  logic       vld_r, vld_nxt;
  logic [7:0] ch_r;

  assign in_tready = !vld_r || take;
  assign ch_vld    = vld_r;
  assign ch        = ch_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r <= in_tdata[7:0];
    end
  end

endmodule

@@ hw/rtl/mcld_parser.sv @@
// ----------------------------------------------------------------------------
// Command line parser
// Token, keyword and number tracking per character; builds the result at
// the newline.
// ----------------------------------------------------------------------------
module mcld_parser import mcld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ch_vld,
  input  logic [7:0] ch,
  input  logic       out_free,
  output logic       take,
  output logic       res_load,
  output result_t    res
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [3:0]  cand_r, cand_nxt;
  logic        fwd_r, fwd_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] val_r [NUM_TOKENS];
  logic [31:0] val_nxt [NUM_TOKENS];
  logic [NUM_TOKENS-1:0] neg_r, neg_nxt, dig_r, dig_nxt, ovf_r, ovf_nxt;

  logic        is_nl, is_sp, is_blank, is_digit, is_sign;
  logic        num_act, sign_ev, digit_ev;
  logic [1:0]  tsel;
  logic [31:0] cur_val, new_val;
  logic [35:0] mul;
  logic        over;

  logic [3:0]  len_mask;
  logic [3:0]  char_mask;
  logic [3:0]  et_cand;
  logic        et_fwd;
  logic [2:0]  et_cnt;
  logic [2:0]  cnt_fin;
  logic [3:0]  cand_fin;
  logic        fwd_fin;
  logic        res_vld;

  kind_t       kind;
  logic        need4;
  logic [2:0]  need;
  logic [1:0]  asel;
  logic        ok_idx, ok_amt;

  assign is_nl    = (ch == CH_NL);
  assign is_sp    = (ch == CH_SP);
  assign is_blank = (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

  assign take     = ch_vld && (!is_nl || out_free);
  assign res_load = take && is_nl && res_vld;

  // tokens two to four carry numbers
  assign num_act = (cnt_r >= 3'd1) && (cnt_r <= 3'd3);
  assign tsel    = cnt_r[1:0] - 2'd1;

  always_comb begin
    case (tsel)
      2'd0:    cur_val = val_r[0];
      2'd1:    cur_val = val_r[1];
      default: cur_val = val_r[2];
    endcase
  end

  // v*10 + digit as two shifts and two adds
  assign mul     = {1'b0, cur_val, 3'b000} + {3'b000, cur_val, 1'b0}
                 + {28'd0, ch - CH_ZERO};
  assign over    = (mul > {4'd0, MAG_CAP});
  assign new_val = over ? MAG_CAP : mul[31:0];

  // number parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_sp || is_nl) begin
      phase_nxt = PH_SKIP;
    end else if (num_act) begin
      case (phase_r)
        PH_DONE: phase_nxt = PH_DONE;
        default: begin
          if (phase_r == PH_SKIP && is_blank) begin
            phase_nxt = PH_SKIP;
          end else if (phase_r == PH_SKIP && is_sign) begin
            phase_nxt = PH_SIGN;
          end else if (!is_digit) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_DIGITS;
          end
        end
      endcase
    end
  end

  always_comb begin
    sign_ev  = 1'b0;
    digit_ev = 1'b0;
    if (!is_sp && !is_nl && num_act && phase_r != PH_DONE) begin
      if (phase_r == PH_SKIP && is_blank) begin
        sign_ev = 1'b0;
      end else if (phase_r == PH_SKIP && is_sign) begin
        sign_ev = (ch == CH_MINUS);
      end else begin
        digit_ev = is_digit;
      end
    end
  end

  // effects of closing the current token
  always_comb begin
    for (int k = 0; k < KW_CNT; k++) begin
      len_mask[k]  = (len_r == kw_len(2'(k)));
      char_mask[k] = (len_r < kw_len(2'(k))) && (KW_TXT[k][len_r] == ch);
    end
  end

  assign et_cand = (cnt_r == 3'd0) ? (cand_r & len_mask) : cand_r;
  assign et_fwd  = (cnt_r == 3'd2 && len_r != FWD_LEN) ? 1'b0 : fwd_r;
  assign et_cnt  = (cnt_r == TOK_MAX) ? cnt_r : cnt_r + 3'd1;

  // an empty trailing token does not count
  assign cnt_fin  = (len_r != 4'd0) ? et_cnt  : cnt_r;
  assign cand_fin = (len_r != 4'd0) ? et_cand : cand_r;
  assign fwd_fin  = (len_r != 4'd0) ? et_fwd  : fwd_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    cand_nxt = cand_r;
    fwd_nxt  = fwd_r;
    neg_nxt  = neg_r;
    dig_nxt  = dig_r;
    ovf_nxt  = ovf_r;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      val_nxt[t] = val_r[t];
    end
    if (is_sp) begin
      cnt_nxt  = et_cnt;
      cand_nxt = et_cand;
      fwd_nxt  = et_fwd;
      len_nxt  = 4'd0;
    end else if (!is_nl) begin
      if (cnt_r == 3'd0) begin
        cand_nxt = cand_r & char_mask;
      end
      if (cnt_r == 3'd2 && (len_r >= FWD_LEN || FWD_TXT[len_r[2:0]] != ch)) begin
        fwd_nxt = 1'b0;
      end
      if (sign_ev) begin
        neg_nxt[tsel] = 1'b1;
      end
      if (digit_ev) begin
        dig_nxt[tsel] = 1'b1;
        val_nxt[tsel] = new_val;
        if (over) begin
          ovf_nxt[tsel] = 1'b1;
        end
      end
      if (len_r != LEN_MAX) begin
        len_nxt = len_r + 4'd1;
      end
    end else begin
      cnt_nxt  = 3'd0;
      len_nxt  = 4'd0;
      cand_nxt = 4'hF;
      fwd_nxt  = 1'b1;
      neg_nxt  = '0;
      dig_nxt  = '0;
      ovf_nxt  = '0;
      for (int t = 0; t < NUM_TOKENS; t++) begin
        val_nxt[t] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      len_r   <= 4'd0;
      cand_r  <= 4'hF;
      fwd_r   <= 1'b1;
      phase_r <= PH_SKIP;
      neg_r   <= '0;
      dig_r   <= '0;
      ovf_r   <= '0;
      for (int t = 0; t < NUM_TOKENS; t++) begin
        val_r[t] <= 32'd0;
      end
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
      fwd_r   <= fwd_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      dig_r   <= dig_nxt;
      ovf_r   <= ovf_nxt;
      for (int t = 0; t < NUM_TOKENS; t++) begin
        val_r[t] <= val_nxt[t];
      end
    end
  end

  // result at the newline
  assign res_vld = (cnt_fin != 3'd0) && (cand_fin != 4'd0);

  always_comb begin
    if (cand_fin[0]) begin
      kind = KIND_DC;
    end else if (cand_fin[1]) begin
      kind = KIND_DC_ENC;
    end else if (cand_fin[2]) begin
      kind = KIND_STEPPER;
    end else begin
      kind = KIND_SERVO;
    end
  end

  assign need4 = (kind == KIND_DC) || (kind == KIND_STEPPER);
  assign need  = need4 ? 3'd4 : 3'd3;
  assign asel  = need4 ? 2'd2 : 2'd1;

  assign ok_idx = dig_r[0] && !ovf_r[0] &&
                  (val_r[0] <= (neg_r[0] ? MAG_NEG_MAX : MAG_POS_MAX));
  assign ok_amt = dig_r[asel] && !ovf_r[asel] &&
                  (val_r[asel] <= (neg_r[asel] ? MAG_NEG_MAX : MAG_POS_MAX));

  always_comb begin
    res.kind         = kind;
    res.status       = ST_OK;
    res.device_index = 32'd0;
    res.reverse      = 1'b0;
    res.amount       = 32'd0;
    if (cnt_fin != need) begin
      res.status = ST_TOKEN_COUNT;
    end else if (!(ok_idx && ok_amt)) begin
      res.status = ST_BAD_NUMBER;
    end else begin
      res.device_index = neg_r[0] ? (32'd0 - val_r[0]) : val_r[0];
      res.reverse      = need4 && !fwd_fin;
      res.amount       = neg_r[asel] ? (32'd0 - val_r[asel]) : val_r[asel];
    end
  end

endmodule

@@ hw/rtl/mcld_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded command until the downstream side takes it.
// ----------------------------------------------------------------------------
module mcld_out_stage import mcld_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  result_t                res,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status, device_index, reverse, amount
  output logic [OUT_TUSER_W-1:0] out_tuser   // kind
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {5'b00000, res_r.amount, res_r.reverse, res_r.device_index,
                       res_r.status};
  assign out_tuser  = res_r.kind;

endmodule

@@ hw/rtl/motor_command_line_decoder.sv @@
// ----------------------------------------------------------------------------
// Motor command line decoder
// Decodes DC, encoder DC, stepper and servo command lines from ASCII text.
// ----------------------------------------------------------------------------
// One character is taken per clock. A character passes an input register,
// updates the token, keyword and number trackers and, at a newline, loads
// the result register, which drives out_tvalid. Only a newline waits, and
// only while the result register still holds a result that is not taken in
// that cycle; other characters keep flowing. The command kind travels on out_tuser.
// Lines that are empty or do not start with a known keyword give no result.
// ----------------------------------------------------------------------------
module motor_command_line_decoder import mcld_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] ch
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [1:0] status, [33:2] device_index,
                                              // [34] reverse, [66:35] amount
  output logic [OUT_TUSER_W-1:0] out_tuser    // [1:0] kind
);

  logic       ch_vld;
  logic [7:0] ch;
  logic       take;
  logic       res_load;
  logic       out_free;
  result_t    res;

  assign out_free = !out_tvalid || out_tready;

  mcld_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .ch_vld    (ch_vld),
    .ch        (ch)
  );

  mcld_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch_vld   (ch_vld),
    .ch       (ch),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  mcld_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_load),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ dv/motor_command_line_checker.sv @@
// ----------------------------------------------------------------------------
// Motor command line checker
// Watches both stream channels of the decoder, rebuilds every command from
// the accepted characters and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module motor_command_line_checker
  import mcld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] ch
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,   // [1:0] status, [33:2] device_index,
                                              // [34] reverse, [66:35] amount
  input  logic [OUT_TUSER_W-1:0] out_tuser,   // [1:0] kind
  output int unsigned            mismatch_cnt,
  output int unsigned            cmds_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [31:0] index;
    logic        reverse;
    logic [31:0] amount;
  } motor_cmd_t;

  localparam logic [32:0] NUM_CLAMP = 33'h0_8000_0001;
  localparam string       ENC_WORD  = {"DC_", "encoder"};

  string kw_word [4] = '{"DC", ENC_WORD, "Stepper", "Servo"};
  string fwd_word    = "Forward";

  motor_cmd_t expected_cmds [$];

  // line tracker
  logic [2:0]  tok_cnt;
  logic [3:0]  tok_len;
  logic [3:0]  kw_alive;
  logic        fwd_ok;
  phase_t      num_phase;
  logic [32:0] num_mag [1:3];
  bit          num_neg [1:3];
  bit          num_dig [1:3];
  bit          num_ovf [1:3];

  function automatic void clear_line();
    tok_cnt   = '0;
    tok_len   = '0;
    kw_alive  = 4'hF;
    fwd_ok    = 1'b1;
    num_phase = PH_SKIP;
    for (int t = 1; t <= 3; t++) begin
      num_mag[t] = '0;
      num_neg[t] = 1'b0;
      num_dig[t] = 1'b0;
      num_ovf[t] = 1'b0;
    end
  endfunction

  function automatic void close_token();
    if (tok_cnt == 0) begin
      for (int k = 0; k < 4; k++) begin
        if (tok_len != kw_word[k].len()) kw_alive[k] = 1'b0;
      end
    end
    if (tok_cnt == 2 && tok_len != fwd_word.len()) fwd_ok = 1'b0;
    if (tok_cnt != 3'd7) tok_cnt++;
    tok_len   = '0;
    num_phase = PH_SKIP;
  endfunction

  function automatic bit number_value(input int t, output logic [31:0] val);
    val = '0;
    if (!num_dig[t] || num_ovf[t]) return 1'b0;
    if (num_mag[t] > (num_neg[t] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF)) return 1'b0;
    val = num_neg[t] ? 32'd0 - num_mag[t][31:0] : num_mag[t][31:0];
    return 1'b1;
  endfunction

  // Advances the line tracker by one character; a newline may queue a command.
  function automatic void decode_char(input logic [7:0] c);
    logic [3:0]  p;
    int          t;
    logic [63:0] v;
    bit          digit;
    bit          blank;
    kind_t       cmd_kind;
    int          need;
    motor_cmd_t  cmd;
    logic [31:0] idx;
    logic [31:0] amt;
    bit          idx_ok;
    bit          amt_ok;

    p = tok_len;
    if (c == CH_SP) begin
      close_token();
      return;
    end

    if (c != CH_NL) begin
      if (tok_cnt == 0) begin
        for (int k = 0; k < 4; k++) begin
          if (p >= kw_word[k].len() || kw_word[k][p] != c) kw_alive[k] = 1'b0;
        end
      end
      if (tok_cnt == 2 && (p >= fwd_word.len() || fwd_word[p] != c)) fwd_ok = 1'b0;
      if (tok_cnt >= 1 && tok_cnt <= 3) begin
        t     = tok_cnt;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        blank = (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR);
        if (num_phase != PH_DONE && !(num_phase == PH_SKIP && blank)) begin
          if (num_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) num_neg[t] = 1'b1;
            num_phase = PH_SIGN;
          end else if (!digit) begin
            num_phase = PH_DONE;
          end else begin
            num_phase  = PH_DIGITS;
            num_dig[t] = 1'b1;
            v = 64'(num_mag[t]) * 64'd10 + 64'(c - CH_ZERO);
            // clamp once past any 32-bit value so the magnitude stays bounded
            if (v > 64'(NUM_CLAMP)) begin
              v          = 64'(NUM_CLAMP);
              num_ovf[t] = 1'b1;
            end
            num_mag[t] = v[32:0];
          end
        end
      end
      if (tok_len != 4'd15) tok_len++;
      return;
    end

    // newline: an open non-empty token still counts
    if (tok_len != 0) close_token();
    if (tok_cnt == 0 || kw_alive == 4'b0) begin
      clear_line();
      return;
    end
    if (kw_alive[KIND_DC])           cmd_kind = KIND_DC;
    else if (kw_alive[KIND_DC_ENC])  cmd_kind = KIND_DC_ENC;
    else if (kw_alive[KIND_STEPPER]) cmd_kind = KIND_STEPPER;
    else                             cmd_kind = KIND_SERVO;
    need = (cmd_kind == KIND_DC || cmd_kind == KIND_STEPPER) ? 4 : 3;

    cmd.kind    = cmd_kind;
    cmd.status  = ST_OK;
    cmd.index   = '0;
    cmd.reverse = 1'b0;
    cmd.amount  = '0;
    if (tok_cnt != need) begin
      cmd.status = ST_TOKEN_COUNT;
    end else begin
      idx_ok = number_value(1, idx);
      amt_ok = number_value(need - 1, amt);
      if (!(idx_ok && amt_ok)) begin
        cmd.status = ST_BAD_NUMBER;
      end else begin
        cmd.index   = idx;
        cmd.reverse = (need == 4) ? !fwd_ok : 1'b0;
        cmd.amount  = amt;
      end
    end
    expected_cmds = {expected_cmds, cmd};
    clear_line();
  endfunction

  always @(posedge clk) begin
    motor_cmd_t want;
    motor_cmd_t got;
    logic [4:0] pad;

    if (!rst_n) begin
      clear_line();
      expected_cmds.delete();
    end else begin
      // a result can never come from the character taken at the same edge
      if (out_tvalid && out_tready) begin
        got.kind    = kind_t'(out_tuser[1:0]);
        got.status  = status_t'(out_tdata[1:0]);
        got.index   = out_tdata[33:2];
        got.reverse = out_tdata[34];
        got.amount  = out_tdata[66:35];
        pad         = out_tdata[71:67];
        if (expected_cmds.size() == 0) begin
          $error("unexpected result transfer: kind %0d status %0d",
                 got.kind, got.status);
          mismatch_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatch_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_cnt++;
          end
          if (got.index !== want.index) begin
            $error("device_index: expected %0d, got %0d",
                   $signed(want.index), $signed(got.index));
            mismatch_cnt++;
          end
          if (got.reverse !== want.reverse) begin
            $error("reverse: expected %0d, got %0d", want.reverse, got.reverse);
            mismatch_cnt++;
          end
          if (got.amount !== want.amount) begin
            $error("amount: expected %0d, got %0d",
                   $signed(want.amount), $signed(got.amount));
            mismatch_cnt++;
          end
          if (pad !== 5'b00000) begin
            $error("tdata padding: expected 0, got %0d", pad);
            mismatch_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_char(in_tdata);
    end
    cmds_pending = expected_cmds.size();
  end

endmodule

@@ dv/motor_command_line_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// Motor command line decoder testbench
// Feeds directed and random command lines character by character, with
// random gaps on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module motor_command_line_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcld_pkg::*;

  localparam string ENC_WORD = {"DC_", "encoder"};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned mismatch_cnt;
  int unsigned cmds_pending;

  int          phase_id    = 0;
  int unsigned tx_idle_pct = 15;
  int unsigned chars_sent  = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  logic [7:0]  line_q [$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  motor_command_line_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  motor_command_line_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatch_cnt (mismatch_cnt),
    .cmds_pending (cmds_pending)
  );

  // Result side: random stalls per phase, plus one long hold at the start of
  // the last phase so the decoder backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (phase_id == 2 && !hold_done) begin
      hold_left  <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99, 0) >=
                    ((phase_id == 0) ? 48 : (phase_id == 1) ? 15 : 0);
    end
  end

  task automatic add_char(input logic [7:0] c);
    line_q = {line_q, c};
  endtask

  task automatic push_char(input logic [7:0] c);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_line();
    add_char(CH_NL);
    foreach (line_q[i]) push_char(line_q[i]);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_char(s[i]);
  endtask

  task automatic add_blanks();
    int unsigned n;
    n = $urandom_range(3, 1);
    repeat (n) begin
      case ($urandom_range(3, 0))
        0:       add_char(CH_TAB);
        1:       add_char(CH_VT);
        2:       add_char(CH_FF);
        default: add_char(CH_CR);
      endcase
    end
  endtask

  task automatic add_word();
    int unsigned n;
    n = $urandom_range(17, 0);
    repeat (n) add_char(8'($urandom_range(126, 33)));
  endtask

  task automatic add_number();
    string       limits [10] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                                 "4294967295", "2147483649", "-0", "+0",
                                 "00000000002147483647", "9999999999"};
    string       tails [4]   = '{"ab", "+3", "-", "9x"};
    string       broken [6]  = '{"", "-", "+", "+-5", "abc", "--1"};
    int unsigned n;

    case ($urandom_range(9, 0))
      0, 1, 2: begin
        if ($urandom_range(1, 0)) add_char($urandom_range(1, 0) ? CH_MINUS : CH_PLUS);
        add_text($sformatf("%0d", $urandom_range(9999, 0)));
      end
      3, 4: add_text($sformatf("%0d", $signed($urandom())));
      5:    add_text(limits[$urandom_range(9, 0)]);
      6: begin
        n = $urandom_range(20, 10);
        if ($urandom_range(1, 0)) add_char(CH_MINUS);
        repeat (n) add_char(CH_ZERO + 8'($urandom_range(9, 0)));
      end
      7: begin
        // a blank after the sign ends the number with no digits
        if ($urandom_range(1, 0)) begin
          add_char(CH_MINUS);
          add_blanks();
        end else begin
          add_blanks();
          if ($urandom_range(1, 0)) add_char(CH_PLUS);
        end
        add_text($sformatf("%0d", $urandom_range(999, 0)));
      end
      8: begin
        add_text($sformatf("%0d", $urandom_range(500, 0)));
        add_text(tails[$urandom_range(3, 0)]);
      end
      default: add_text(broken[$urandom_range(5, 0)]);
    endcase
  endtask

  task automatic add_direction();
    string       dirs [6] = '{"Backward", "forward", "Forwards", "Forwar", "Forward_", "F"};
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r < 13)      add_text("Forward");
    else if (r < 15) add_word();
    else             add_text(dirs[$urandom_range(5, 0)]);
  endtask

  task automatic add_keyword(input kind_t kd);
    string       kws [4] = '{"DC", ENC_WORD, "Stepper", "Servo"};
    string       s;
    int unsigned pos;
    s = kws[kd];
    if ($urandom_range(19, 0) == 0) begin
      pos    = $urandom_range(s.len() - 1, 0);
      s[pos] = "x";
    end
    add_text(s);
  endtask

  task automatic make_command();
    kind_t       kd;
    int unsigned need;
    int unsigned ntok;
    kd   = kind_t'($urandom_range(3, 0));
    need = (kd == KIND_DC || kd == KIND_STEPPER) ? 4 : 3;
    ntok = ($urandom_range(9, 0) == 0) ? $urandom_range(9, 1) : need;
    add_keyword(kd);
    for (int unsigned i = 2; i <= ntok; i++) begin
      add_char(CH_SP);
      if ($urandom_range(24, 0) == 0) add_char(CH_SP);
      if (i == 2 || i == need)      add_number();
      else if (i == 3 && need == 4) add_direction();
      else if ($urandom_range(1, 0)) add_number();
      else                           add_word();
    end
    if ($urandom_range(9, 0) == 0) add_char(CH_SP);
  endtask

  task automatic random_line();
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    r = $urandom_range(99, 0);
    if (r < 80) begin
      make_command();
    end else if (r < 92) begin
      n = $urandom_range(24, 0);
      repeat (n) begin
        b = 8'($urandom_range(255, 0));
        add_char((b == CH_NL) ? CH_SP : b);
      end
    end else if (r >= 96) begin
      // leading space gives an empty first token
      add_char(CH_SP);
      make_command();
    end
    send_line();
  endtask

  initial begin
    string       directed [22] = '{
      "DC 1 Forward 100", {ENC_WORD, " 2 -90"}, "Stepper -3 Backward 2147483647",
      "Servo +4 -2147483648", "DC 0 Forward 2147483648", "Servo 1 -2147483649",
      "DC 1 Forward", "DC  1 Forward 5", "Stepper 1 x 5 ", "Servo 5 -", "",
      "Motor 1 2", "DCX 1 Forward 3", {ENC_WORD, "_long_token 1 2"},
      "DC 1 Forward 2 3 4 5 6 7 8", "Servo 99999999999999999999 1",
      "DC 1 Forwards 10", "Stepper 1 Forwar 10", " DC 1 Forward 2",
      "DC 00000000000000000007 Forward -0", {ENC_WORD, " x1 5"}, "Servo 3"};
    int unsigned target;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      add_text(directed[i]);
      send_line();
    end
    add_text("Servo ");
    add_char(CH_TAB);
    add_char(CH_CR);
    add_text("7 12abc");
    send_line();
    add_text("Servo 1 -");
    add_char(CH_VT);
    add_text("5");
    send_line();
    add_text({ENC_WORD, " "});
    add_char(CH_FF);
    add_text("+8 -45");
    send_line();
    add_text("Servo 1 2");
    add_char(8'hFF);
    send_line();
    add_char(8'h00);
    add_text("DC 1 Forward 1");
    send_line();

    for (int p = 0; p < 3; p++) begin
      phase_id    <= p;
      tx_idle_pct = (p == 0) ? 15 : (p == 1) ? 48 : 0;
      target      = chars_sent + 250;
      while (chars_sent < target) random_line();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (cmds_pending == 0);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
